>>> design/smrf_pkg.sv
`default_nettype none

package smrf_pkg;

  // field widths of the item and result channels
  localparam int CMD_W    = 1;
  localparam int SAMPLE_W = 24;
  localparam int IDX_W    = 4;
  localparam int DELAY_W  = 13;
  localparam int GAIN_W   = 18;
  localparam int COEFF_W  = 16;

  // internal widths: tap input and lowpass state, shared multiplier
  localparam int Y_W      = SAMPLE_W + 1;
  localparam int PROD_W   = Y_W + GAIN_W;

  // rounding offsets and shifts of the fixed-point datapath
  localparam int X_SHIFT  = 17;
  localparam int Y_SHIFT  = 16;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  localparam int SAT_MAX = 8388607;
  localparam int SAT_MIN = -8388608;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_TAB,
    S_ADDR,
    S_MULP,
    S_XRND,
    S_MULA,
    S_MULB,
    S_FILT,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

>>> design/stereo_multitap_reflection_filter.sv
`default_nettype none

// Stereo early-reflection generator: two circular delay memories with
// NUM_TAPS taps per channel, each tap scaled by its gain and smoothed by its
// own one-pole lowpass, all taps of a channel summed and saturated to 24 bits.
//
// Input channel (item_valid / item_stall): cmd 0 carries a sample pair and
// yields one result; cmd 1 loads one tap entry and yields nothing.
// Output channel (result_valid / result_stall): out_left / out_right.
//
// A sample item walks 2 x NUM_TAPS taps through one shared multiplier, each
// tap in turn through table read, memory read, gain multiply, rounding, two
// lowpass multiplies and the lowpass update. No new item is taken until the
// result of a sample item is in the output register or a tap load is done.
// A tap load wraps its delay by subtracting BUF_DEPTH until it fits the
// buffer, then writes its table entry.
//
// Reset clears the pointer, tap and lowpass valid bits and the output valid
// flag; delay memory entries not yet written are taken as zero, so no
// clearing pass is run. While a result waits under result_stall the block
// finishes the next item and then holds it until the output register is free.

module stereo_multitap_reflection_filter #(
  parameter int NUM_TAPS  = 16,
  parameter int BUF_DEPTH = 8192
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  logic [smrf_pkg::CMD_W-1:0]            cmd,
  input  logic signed [smrf_pkg::SAMPLE_W-1:0]  sample_left,
  input  logic signed [smrf_pkg::SAMPLE_W-1:0]  sample_right,
  input  logic                                  tap_channel,
  input  logic [smrf_pkg::IDX_W-1:0]            tap_index,
  input  logic [smrf_pkg::DELAY_W-1:0]          tap_delay,
  input  logic signed [smrf_pkg::GAIN_W-1:0]    tap_gain,
  input  logic [smrf_pkg::COEFF_W-1:0]          tap_coeff,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic signed [smrf_pkg::SAMPLE_W-1:0]  out_left,
  output logic signed [smrf_pkg::SAMPLE_W-1:0]  out_right
);
  import smrf_pkg::*;

  localparam int TAP_W = $clog2(NUM_TAPS);
  localparam int TAB_N = 2 * (2 ** TAP_W);
  localparam int AW    = $clog2(BUF_DEPTH);
  localparam int SUM_W = Y_W + TAP_W;

  localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(SAT_MAX);
  localparam logic signed [SUM_W-1:0] SUM_LO = SUM_W'(SAT_MIN);
  localparam logic signed [Y_W-1:0]   X_HI   = Y_W'(SAT_MAX) + Y_W'(1);
  localparam logic signed [Y_W-1:0]   X_LO   = Y_W'(SAT_MIN);

  state_t state, state_next;

  logic          take;
  logic          take_sample;
  logic          take_load;
  logic          idx_ok;

  logic [AW-1:0] wp;
  logic          wrapped;

  logic               tap_ch;
  logic [TAP_W-1:0]   tap_num;
  logic [TAP_W:0]     tab_addr;
  logic               last_tap;

  // tap table and lowpass state memories
  logic [AW-1:0]              tab_delay_mem [TAB_N];
  logic signed [GAIN_W-1:0]   tab_gain_mem  [TAB_N];
  logic [COEFF_W-1:0]         tab_coeff_mem [TAB_N];
  logic [TAB_N-1:0]           tab_valid;
  logic signed [Y_W-1:0]      fst_mem [TAB_N];
  logic [TAB_N-1:0]           fst_valid;

  logic [AW-1:0]              tab_delay_q;
  logic signed [GAIN_W-1:0]   tab_gain_q;
  logic [COEFF_W-1:0]         tab_coeff_q;
  logic                       tab_ok;
  logic signed [Y_W-1:0]      fst_q;
  logic                       fst_ok;

  logic [AW-1:0]              dly_eff;
  logic signed [GAIN_W-1:0]   gain_eff;
  logic [COEFF_W-1:0]         coeff_eff;
  logic signed [Y_W-1:0]      yprev_eff;
  logic [COEFF_W:0]           inv_coeff;

  logic [AW:0]                diff;
  logic [AW-1:0]              rd_addr;
  logic                       rd_ok;

  // pending tap load
  logic                       ld_ch;
  logic [TAP_W-1:0]           ld_idx;
  logic [TAP_W:0]             ld_addr;
  logic signed [GAIN_W-1:0]   ld_gain;
  logic [COEFF_W-1:0]         ld_coeff;
  logic [DELAY_W-1:0]         rem;
  logic                       rem_fits;

  logic signed [SAMPLE_W-1:0] left_q;
  logic signed [SAMPLE_W-1:0] right_q;
  logic signed [SAMPLE_W-1:0] sample_op;

  logic signed [Y_W-1:0]      mul_a;
  logic signed [GAIN_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]   mul_p;

  logic signed [PROD_W-1:0]   p;
  logic signed [PROD_W-1:0]   p_rnd;
  logic signed [Y_W-1:0]      x;
  logic signed [PROD_W-1:0]   acc;
  logic signed [Y_W-1:0]      y;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SUM_W-1:0]    sum_fin;
  logic signed [SAMPLE_W-1:0] sat_val;
  logic signed [SAMPLE_W-1:0] res_left;
  logic signed [SAMPLE_W-1:0] res_right;
  logic                       out_free;

  assign item_stall  = (state != S_IDLE);
  assign take        = item_valid && !item_stall;
  assign take_sample = take && (cmd == CMD_SAMPLE);
  assign take_load   = take && (cmd == CMD_LOAD);
  assign idx_ok      = (32'(tap_index) < NUM_TAPS);

  assign tab_addr = {tap_ch, tap_num};
  assign ld_addr  = {ld_ch, ld_idx};
  assign last_tap = (tap_num == TAP_W'(NUM_TAPS - 1));
  assign rem_fits = (32'(rem) < BUF_DEPTH);
  assign out_free = !result_valid || !result_stall;

  // entries never loaded read as delay one, gain zero, coefficient zero
  assign dly_eff   = tab_ok ? tab_delay_q : AW'(1);
  assign gain_eff  = tab_ok ? tab_gain_q : '0;
  assign coeff_eff = tab_ok ? tab_coeff_q : '0;
  assign yprev_eff = fst_ok ? fst_q : '0;
  assign inv_coeff = (COEFF_W+1)'(1 << COEFF_W) - {1'b0, coeff_eff};

  // read address = write pointer minus delay, wrapped into the buffer
  assign diff    = {1'b0, wp} - {1'b0, dly_eff};
  assign rd_addr = diff[AW] ? AW'(diff + (AW+1)'(BUF_DEPTH)) : diff[AW-1:0];

  assign sample_op = rd_ok ? (tap_ch ? right_q : left_q) : '0;

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MULP: begin
        mul_a = Y_W'(sample_op);
        mul_b = gain_eff;
      end
      S_MULA: begin
        mul_a = x;
        mul_b = $signed({1'b0, inv_coeff});
      end
      S_MULB: begin
        mul_a = yprev_eff;
        mul_b = $signed({2'b00, coeff_eff});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign p_rnd   = p + (PROD_W'(1) <<< (X_SHIFT - 1));
  assign y       = acc[Y_SHIFT +: Y_W];
  assign sum_fin = sum + SUM_W'(y);

  always_comb begin
    if (sum_fin > SUM_HI) begin
      sat_val = SAMPLE_W'(SAT_MAX);
    end else if (sum_fin < SUM_LO) begin
      sat_val = SAMPLE_W'(SAT_MIN);
    end else begin
      sat_val = sum_fin[SAMPLE_W-1:0];
    end
  end

  smrf_delay_ram #(
    .DEPTH  (BUF_DEPTH),
    .ADDR_W (AW)
  ) u_left_ram (
    .clk   (clk),
    .we    (take_sample),
    .waddr (wp),
    .wdata (sample_left),
    .re    (state == S_ADDR),
    .raddr (rd_addr),
    .rdata (left_q)
  );

  smrf_delay_ram #(
    .DEPTH  (BUF_DEPTH),
    .ADDR_W (AW)
  ) u_right_ram (
    .clk   (clk),
    .we    (take_sample),
    .waddr (wp),
    .wdata (sample_right),
    .re    (state == S_ADDR),
    .raddr (rd_addr),
    .rdata (right_q)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (take_sample) begin
          state_next = S_TAB;
        end else if (take_load && idx_ok) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        if (rem_fits) begin
          state_next = S_IDLE;
        end
      end
      S_TAB:  state_next = S_ADDR;
      S_ADDR: state_next = S_MULP;
      S_MULP: state_next = S_XRND;
      S_XRND: state_next = S_MULA;
      S_MULA: state_next = S_MULB;
      S_MULB: state_next = S_FILT;
      S_FILT: begin
        if (last_tap && tap_ch) begin
          state_next = S_DONE;
        end else begin
          state_next = S_TAB;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      wp           <= '0;
      wrapped      <= 1'b0;
      tap_ch       <= 1'b0;
      tap_num      <= '0;
      tab_valid    <= '0;
      fst_valid    <= '0;
      result_valid <= 1'b0;
    end else begin
      if (take_sample) begin
        tap_ch  <= 1'b0;
        tap_num <= '0;
      end
      if (state == S_LOAD && rem_fits) begin
        tab_valid[ld_addr] <= 1'b1;
      end
      if (state == S_FILT) begin
        fst_valid[tab_addr] <= 1'b1;
        if (last_tap) begin
          tap_num <= '0;
          tap_ch  <= 1'b1;
        end else begin
          tap_num <= tap_num + TAP_W'(1);
        end
      end
      if (state == S_DONE && out_free) begin
        result_valid <= 1'b1;
        if (32'(wp) == BUF_DEPTH - 1) begin
          wp      <= '0;
          wrapped <= 1'b1;
        end else begin
          wp <= wp + AW'(1);
        end
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // tap table and lowpass state memories
  always_ff @(posedge clk) begin
    if (state == S_LOAD && rem_fits) begin
      tab_delay_mem[ld_addr] <= AW'(rem);
      tab_gain_mem[ld_addr]  <= ld_gain;
      tab_coeff_mem[ld_addr] <= ld_coeff;
    end
    if (state == S_TAB) begin
      tab_delay_q <= tab_delay_mem[tab_addr];
      tab_gain_q  <= tab_gain_mem[tab_addr];
      tab_coeff_q <= tab_coeff_mem[tab_addr];
      tab_ok      <= tab_valid[tab_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FILT) begin
      fst_mem[tab_addr] <= y;
    end
    if (state == S_TAB) begin
      fst_q  <= fst_mem[tab_addr];
      fst_ok <= fst_valid[tab_addr];
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (take_load) begin
      ld_ch    <= tap_channel;
      ld_idx   <= TAP_W'(tap_index);
      ld_gain  <= tap_gain;
      ld_coeff <= tap_coeff;
      rem      <= tap_delay;
    end
    // wrap the delay into the buffer one subtraction per cycle
    if (state == S_LOAD && !rem_fits) begin
      rem <= rem - DELAY_W'(BUF_DEPTH);
    end
    if (take_sample) begin
      sum <= '0;
    end
    case (state)
      S_ADDR: rd_ok <= wrapped || (rd_addr <= wp);
      S_MULP: p     <= mul_p;
      S_XRND: x     <= p_rnd[X_SHIFT +: Y_W];
      S_MULA: acc   <= mul_p + (PROD_W'(1) <<< (Y_SHIFT - 1));
      S_MULB: acc   <= acc + mul_p;
      S_FILT: begin
        if (last_tap) begin
          sum <= '0;
          if (tap_ch) begin
            res_right <= sat_val;
          end else begin
            res_left <= sat_val;
          end
        end else begin
          sum <= sum_fin;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_left  <= res_left;
          out_right <= res_right;
        end
      end
      default: begin
      end
    endcase
  end

  // a finished item must not overwrite a result still held by the receiver
  a_hold_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && result_valid && result_stall) |=> (state == S_DONE))
    else $error("finished item left while result was stalled");

  // a sample item starts at the first left tap
  a_start: assert property (@(posedge clk) disable iff (rst)
    (take_sample) |=> (state == S_TAB && !tap_ch && tap_num == '0))
    else $error("sample item did not start at first tap");

  // tap counter stays inside the configured tap count
  a_tap_range: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && state != S_LOAD && state != S_DONE)
      |-> (32'(tap_num) < NUM_TAPS))
    else $error("tap counter out of range");

  // rounded tap input lies within plus or minus one full scale
  a_x_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MULA) |-> (x >= X_LO - Y_W'(0) && x <= X_HI))
    else $error("tap input out of range");

endmodule

`default_nettype wire

>>> design/smrf_delay_ram.sv
`default_nettype none

module smrf_delay_ram #(
  parameter int DEPTH  = 8192,
  parameter int ADDR_W = 13
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [ADDR_W-1:0]                   waddr,
  input  logic signed [smrf_pkg::SAMPLE_W-1:0] wdata,
  input  logic                                re,
  input  logic [ADDR_W-1:0]                   raddr,
  output logic signed [smrf_pkg::SAMPLE_W-1:0] rdata
);
  import smrf_pkg::*;

  logic signed [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import smrf_pkg::*;

  localparam int NUM_TAPS    = 16;
  localparam int BUF_DEPTH   = 8192;
  localparam int QUIET_LIMIT = 5000;
  localparam int DRAIN_WAIT  = 300;
  localparam int REPORT_CAP  = 200;

  localparam logic signed [SAMPLE_W-1:0] S_MAX = SAMPLE_W'(SAT_MAX);
  localparam logic signed [SAMPLE_W-1:0] S_MIN = SAMPLE_W'(SAT_MIN);
  localparam logic signed [GAIN_W-1:0]   G_MAX = GAIN_W'(131071);
  localparam logic signed [GAIN_W-1:0]   G_MIN = GAIN_W'(-131072);
  localparam logic [COEFF_W-1:0]         C_MAX = 16'hFFFF;
  localparam logic                       CH_LEFT  = 1'b0;
  localparam logic                       CH_RIGHT = 1'b1;

  typedef struct {
    logic [CMD_W-1:0]           cmd;
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic                       chan;
    logic [IDX_W-1:0]           idx;
    logic [DELAY_W-1:0]         delay;
    logic signed [GAIN_W-1:0]   gain;
    logic [COEFF_W-1:0]         coeff;
  } filter_item_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } stereo_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [CMD_W-1:0] cmd = CMD_SAMPLE;
  logic signed [SAMPLE_W-1:0] sample_left = '0;
  logic signed [SAMPLE_W-1:0] sample_right = '0;
  logic tap_channel = 1'b0;
  logic [IDX_W-1:0] tap_index = '0;
  logic [DELAY_W-1:0] tap_delay = '0;
  logic signed [GAIN_W-1:0] tap_gain = '0;
  logic [COEFF_W-1:0] tap_coeff = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] out_left;
  logic signed [SAMPLE_W-1:0] out_right;

  // predictor state: delay history, tap table and per-tap lowpass memory
  logic signed [SAMPLE_W-1:0] hist_left [BUF_DEPTH];
  logic signed [SAMPLE_W-1:0] hist_right [BUF_DEPTH];
  int                         wr_ptr;
  logic [DELAY_W-1:0]         tap_dly [2][NUM_TAPS];
  logic signed [GAIN_W-1:0]   tap_gn [2][NUM_TAPS];
  int                         tap_cf [2][NUM_TAPS];
  int                         lp_mem [2][NUM_TAPS];

  stereo_out_t pending_outputs[$];
  stereo_out_t due;
  int errors = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;

  stereo_multitap_reflection_filter #(
    .NUM_TAPS(NUM_TAPS),
    .BUF_DEPTH(BUF_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .cmd(cmd),
    .sample_left(sample_left),
    .sample_right(sample_right),
    .tap_channel(tap_channel),
    .tap_index(tap_index),
    .tap_delay(tap_delay),
    .tap_gain(tap_gain),
    .tap_coeff(tap_coeff),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .out_left(out_left),
    .out_right(out_right)
  );

  always #2 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    if ($urandom_range(0, 9) != 0) return $urandom_range(0, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    logic signed [SAMPLE_W-1:0] s;
    case ($urandom_range(0, 9))
      0: s = S_MAX;
      1: s = S_MIN;
      2: s = SAMPLE_W'($signed($urandom_range(0, 2000)) - 1000);
      default: s = SAMPLE_W'($urandom());
    endcase
    return s;
  endfunction

  function automatic filter_item_t make_sample(logic signed [SAMPLE_W-1:0] l,
                                               logic signed [SAMPLE_W-1:0] r);
    filter_item_t it;
    it.cmd   = CMD_SAMPLE;
    it.left  = l;
    it.right = r;
    it.chan  = 1'($urandom());
    it.idx   = IDX_W'($urandom());
    it.delay = DELAY_W'($urandom());
    it.gain  = GAIN_W'($urandom());
    it.coeff = COEFF_W'($urandom());
    return it;
  endfunction

  // sample fields of a load are don't-care: fill them with noise
  function automatic filter_item_t make_load(logic ch, int idx, int d,
                                             logic signed [GAIN_W-1:0] g, int c);
    filter_item_t it;
    it.cmd   = CMD_LOAD;
    it.left  = rand_sample();
    it.right = rand_sample();
    it.chan  = ch;
    it.idx   = IDX_W'(idx);
    it.delay = DELAY_W'(d);
    it.gain  = g;
    it.coeff = COEFF_W'(c);
    return it;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] channel_sum(int ch);
    longint sum, p, x, acc, y;
    logic signed [SAMPLE_W-1:0] s;
    int rd;
    sum = 0;
    for (int t = 0; t < NUM_TAPS; t++) begin
      rd  = (wr_ptr + BUF_DEPTH - (int'(tap_dly[ch][t]) % BUF_DEPTH)) % BUF_DEPTH;
      s   = (ch == 0) ? hist_left[rd] : hist_right[rd];
      p   = longint'(s) * longint'(tap_gn[ch][t]);
      x   = (p + 65536) >>> 17;
      acc = longint'(65536 - tap_cf[ch][t]) * x
          + longint'(tap_cf[ch][t]) * longint'(lp_mem[ch][t]) + 32768;
      y   = acc >>> 16;
      lp_mem[ch][t] = int'(y);
      sum += y;
    end
    if (sum > longint'(SAT_MAX)) sum = longint'(SAT_MAX);
    if (sum < longint'(SAT_MIN)) sum = longint'(SAT_MIN);
    return sum[SAMPLE_W-1:0];
  endfunction

  function automatic void predict_reflections(filter_item_t it);
    stereo_out_t o;
    if (it.cmd == CMD_LOAD) begin
      if (32'(it.idx) < NUM_TAPS) begin
        tap_dly[it.chan][it.idx] = it.delay;
        tap_gn[it.chan][it.idx]  = it.gain;
        tap_cf[it.chan][it.idx]  = int'(it.coeff);
      end
    end else begin
      hist_left[wr_ptr]  = it.left;
      hist_right[wr_ptr] = it.right;
      o.left  = channel_sum(0);
      o.right = channel_sum(1);
      pending_outputs.push_back(o);
      wr_ptr = (wr_ptr + 1) % BUF_DEPTH;
    end
  endfunction

  // called right after a rising edge; returns right after the accepting edge
  task automatic send_item(filter_item_t it);
    int gap;
    gap = (tx_idle_on && $urandom_range(0, 1) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd          <= it.cmd;
    sample_left  <= it.left;
    sample_right <= it.right;
    tap_channel  <= it.chan;
    tap_index    <= it.idx;
    tap_delay    <= it.delay;
    tap_gain     <= it.gain;
    tap_coeff    <= it.coeff;
    item_valid   <= 1'b1;
    do @(posedge clk); while (item_stall);
    predict_reflections(it);
  endtask

  task automatic test_idle_taps();
    send_item(make_sample(S_MAX, S_MIN));
    send_item(make_sample(S_MIN, S_MAX));
  endtask

  // two full-scale zero-delay taps per channel push the sum past both rails
  task automatic test_saturation();
    send_item(make_load(CH_LEFT, 0, 0, G_MAX, 0));
    send_item(make_load(CH_LEFT, 1, 0, G_MAX, 0));
    send_item(make_load(CH_RIGHT, 0, 0, G_MIN, 0));
    send_item(make_load(CH_RIGHT, 1, 0, G_MIN, 0));
    send_item(make_sample(S_MAX, S_MAX));
    send_item(make_sample(S_MIN, S_MIN));
  endtask

  task automatic test_lowpass_extremes();
    send_item(make_load(CH_LEFT, 0, 0, GAIN_W'(40000), 0));
    send_item(make_load(CH_RIGHT, 0, 0, GAIN_W'(-3), C_MAX));
    send_item(make_load(CH_LEFT, 1, 1, GAIN_W'(65536), C_MAX));
    send_item(make_load(CH_RIGHT, 1, 2, GAIN_W'(-65536), 32768));
    send_item(make_sample(S_MAX, S_MIN));
    send_item(make_sample(SAMPLE_W'(1234567), SAMPLE_W'(-7654321)));
    send_item(make_sample(-1, 1));
  endtask

  // lowpass memory of a reloaded tap carries over
  task automatic test_reload_while_playing();
    send_item(make_load(CH_LEFT, 1, 3, G_MIN, C_MAX));
    send_item(make_sample(S_MIN, S_MAX));
  endtask

  // longest delay and a delay beyond the write pointer both wrap the address
  task automatic test_far_delays();
    send_item(make_load(CH_LEFT, 2, 8191, G_MAX, 0));
    send_item(make_load(CH_RIGHT, 15, 5000, G_MIN, 1));
    send_item(make_sample(SAMPLE_W'(4000000), SAMPLE_W'(-4000000)));
    send_item(make_sample(S_MAX, S_MAX));
  endtask

  task automatic test_random_traffic(int n);
    int d;
    logic signed [GAIN_W-1:0] g;
    int c;
    for (int k = 0; k < n; k++) begin
      if (k % 150 == 0) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 6) == 0) begin
        case ($urandom_range(0, 9))
          0: d = 0;
          1, 2: d = $urandom_range(0, 8191);
          3: d = 8191;
          default: d = $urandom_range(1, (wr_ptr < 40) ? 40 : wr_ptr + 8);
        endcase
        case ($urandom_range(0, 9))
          0: g = G_MAX;
          1: g = G_MIN;
          default: g = GAIN_W'($urandom());
        endcase
        case ($urandom_range(0, 9))
          0: c = 0;
          1: c = C_MAX;
          default: c = $urandom_range(0, 65535);
        endcase
        send_item(make_load(1'($urandom()), $urandom_range(0, NUM_TAPS - 1), d, g, c));
      end else begin
        send_item(make_sample(rand_sample(), rand_sample()));
      end
    end
  endtask

  // receiver: random stall bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
      stall_left   <= idle_len();
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_outputs.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: result with none expected: left %0d right %0d",
                   $time, out_left, out_right);
      end else begin
        due = pending_outputs.pop_front();
        if (out_left !== due.left) begin
          errors++;
          if (errors <= REPORT_CAP)
            $display("%0t: out_left expected %0d got %0d", $time, due.left, out_left);
        end
        if (out_right !== due.right) begin
          errors++;
          if (errors <= REPORT_CAP)
            $display("%0t: out_right expected %0d got %0d", $time, due.right, out_right);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < BUF_DEPTH; i++) begin
      hist_left[i]  = '0;
      hist_right[i] = '0;
    end
    for (int ch = 0; ch < 2; ch++) begin
      for (int t = 0; t < NUM_TAPS; t++) begin
        tap_dly[ch][t] = DELAY_W'(1);
        tap_gn[ch][t]  = '0;
        tap_cf[ch][t]  = 0;
        lp_mem[ch][t]  = 0;
      end
    end
    wr_ptr = 0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_idle_taps();
    test_saturation();
    test_lowpass_extremes();
    test_reload_while_playing();
    test_far_delays();
    test_random_traffic(1350);
    item_valid <= 1'b0;

    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
